// ===== rtl/pattern_substring_search_core_defines.svh =====
// Assertion macros for the substring search core.
// PSS_ASSERT is disabled while reset is low; PSS_ASSERT_ALWAYS checks at every edge.
`ifndef PATTERN_SUBSTRING_SEARCH_CORE_DEFINES_SVH
`define PATTERN_SUBSTRING_SEARCH_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define PSS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PSS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PSS_ASSERT(label, prop, msg)
`define PSS_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== rtl/pss_pkg.sv =====
`default_nettype none

package pss_pkg;

    // Fixed field widths
    localparam int MODE_W  = 2;
    localparam int SLOT_W  = 4;
    localparam int VALUE_W = 16;
    localparam int COUNT_W = 16;
    localparam int PLEN_W  = 5;

    // Configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // Parameter defaults
    localparam int PATTERN_MAX_DEF  = 16;
    localparam int ELEMENT_BITS_DEF = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Item kinds
    typedef enum logic [MODE_W-1:0] {
        MODE_PATTERN = 2'd0,
        MODE_ELEMENT = 2'd1,
        MODE_END     = 2'd2
    } pss_mode_t;

    // Register indexes
    typedef enum logic [0:0] {
        REG_PATTERN_LENGTH = 1'b0,
        REG_FIND_LAST      = 1'b1
    } pss_reg_t;

    // Per-cycle strobes from the input stage to the datapath
    typedef struct packed {
        logic load;    // pattern slot write
        logic shift;   // haystack element
        logic finish;  // end of haystack
    } pss_step_t;

endpackage

`default_nettype wire

// ===== rtl/pss_if.sv =====
`default_nettype none

// Input word channel
interface pss_in_if;
    logic                         valid;
    logic                         ready;
    logic [pss_pkg::MODE_W-1:0]   mode;
    logic [pss_pkg::SLOT_W-1:0]   slot;
    logic [pss_pkg::VALUE_W-1:0]  value;

    modport source (output valid, mode, slot, value, input ready);
    modport sink   (input valid, mode, slot, value, output ready);
endinterface

// Result word channel
interface pss_out_if;
    logic                         valid;
    logic                         ready;
    logic [pss_pkg::COUNT_W-1:0]  position;
    logic                         found;
    logic [pss_pkg::COUNT_W-1:0]  length;
    logic                         overflow;

    modport source (output valid, position, found, length, overflow, input ready);
    modport sink   (input valid, position, found, length, overflow, output ready);
endinterface

`default_nettype wire

// ===== rtl/pss_cfg.sv =====
`default_nettype none

module pss_cfg #(
    parameter int PATTERN_MAX = pss_pkg::PATTERN_MAX_DEF,
    parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pss_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [pss_pkg::DATA_W-1:0]  pwdata,
    output logic      [pss_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    output logic      [LEN_W-1:0]            used_len,
    output logic                             find_last
);

    logic [pss_pkg::PLEN_W-1:0] plen_reg;
    logic [LEN_W-1:0]           used_len_reg;
    logic                       find_last_reg;
    logic                       wr_en;
    pss_pkg::pss_reg_t          reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = pss_pkg::pss_reg_t'(paddr[2]);

    // Register writes; the clamped length is kept alongside the raw value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg      <= '0;
            used_len_reg  <= '0;
            find_last_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                pss_pkg::REG_PATTERN_LENGTH:
                begin
                    plen_reg <= pwdata[pss_pkg::PLEN_W-1:0];
                    if (32'(pwdata[pss_pkg::PLEN_W-1:0]) > PATTERN_MAX)
                        used_len_reg <= LEN_W'(PATTERN_MAX);
                    else
                        used_len_reg <= LEN_W'(pwdata[pss_pkg::PLEN_W-1:0]);
                end
                pss_pkg::REG_FIND_LAST:
                    find_last_reg <= pwdata[0];
                default:
                    find_last_reg <= find_last_reg;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (reg_sel)
            pss_pkg::REG_PATTERN_LENGTH:
                prdata = {{(pss_pkg::DATA_W-pss_pkg::PLEN_W){1'b0}}, plen_reg};
            pss_pkg::REG_FIND_LAST:
                prdata = {{(pss_pkg::DATA_W-1){1'b0}}, find_last_reg};
            default:
                prdata = '0;
        endcase
    end

    assign used_len  = used_len_reg;
    assign find_last = find_last_reg;

endmodule

`default_nettype wire

// ===== rtl/pss_window.sv =====
`default_nettype none

module pss_window #(
    parameter int PATTERN_MAX  = pss_pkg::PATTERN_MAX_DEF,
    parameter int ELEMENT_BITS = pss_pkg::ELEMENT_BITS_DEF,
    parameter int LEN_W        = $clog2(PATTERN_MAX + 1)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire pss_pkg::pss_step_t          step,
    input  wire logic [pss_pkg::SLOT_W-1:0]  slot,
    input  wire logic [ELEMENT_BITS-1:0]     value,
    input  wire logic [LEN_W-1:0]            used_len,
    output logic                             hit
);

    localparam int PIDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [ELEMENT_BITS-1:0] win_reg [PATTERN_MAX];
    logic [ELEMENT_BITS-1:0] win_next [PATTERN_MAX];
    logic [ELEMENT_BITS-1:0] pat_reg [PATTERN_MAX];

    // Window after the incoming element; entry 0 is the newest
    always_comb
    begin
        win_next[0] = value;
        for (int j = 1; j < PATTERN_MAX; j++)
            win_next[j] = win_reg[j-1];
    end

    // Parallel compare: slot k against window entry used_len-1-k
    always_comb
    begin
        logic               miss;
        logic [PIDX_W-1:0]  sel;
        miss = 1'b0;
        sel  = '0;
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            if (k < int'(used_len))
            begin
                sel = PIDX_W'(int'(used_len) - 1 - k);
                if (win_next[sel] != pat_reg[k])
                    miss = 1'b1;
            end
        end
        hit = !miss && (used_len != '0);
    end

    // Haystack window, cleared at the end of each run
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < PATTERN_MAX; j++)
                win_reg[j] <= '0;
        end
        else if (step.finish)
        begin
            for (int j = 0; j < PATTERN_MAX; j++)
                win_reg[j] <= '0;
        end
        else if (step.shift)
        begin
            win_reg <= win_next;
        end
    end

    // Pattern slots; slots beyond the store are never selected
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            if (step.load && (32'(slot) == j))
                pat_reg[j] <= value;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pss_tracker.sv =====
`default_nettype none

module pss_tracker #(
    parameter int PATTERN_MAX = pss_pkg::PATTERN_MAX_DEF,
    parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pss_pkg::pss_step_t step,
    input  wire logic               hit,
    input  wire logic [LEN_W-1:0]   used_len,
    input  wire logic               find_last,
    output logic                    out_free,
    pss_out_if.source               result
);

    localparam int CW = pss_pkg::COUNT_W;

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] start_reg, start_next;
    logic          seen_reg, seen_next;
    logic [CW-1:0] len_ext;
    logic [CW-1:0] pos;

    logic          out_valid_reg;
    logic [CW-1:0] out_pos_reg;
    logic          out_found_reg;
    logic [CW-1:0] out_len_reg;
    logic          out_ovf_reg;

    assign len_ext  = CW'(used_len);
    assign out_free = !out_valid_reg || result.ready;

    // Run state update
    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        start_next = start_reg;
        seen_next  = seen_reg;
        if (step.finish)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
            start_next = '0;
            seen_next  = 1'b0;
        end
        else if (step.shift)
        begin
            if (count_reg == pss_pkg::COUNT_MAX)
                ovf_next = 1'b1;
            else
                count_next = count_reg + 1'b1;
            if (!ovf_next && hit && (count_next >= len_ext))
            begin
                if (find_last || !seen_reg)
                    start_next = count_next - len_ext;
                seen_next = 1'b1;
            end
        end
    end

    // Reported position
    always_comb
    begin
        if (used_len == '0)
            pos = find_last ? count_reg : '0;
        else
            pos = seen_reg ? start_reg : count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            start_reg <= '0;
            seen_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            start_reg <= start_next;
            seen_reg  <= seen_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step.finish)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step.finish)
        begin
            out_pos_reg   <= pos;
            out_found_reg <= (pos != count_reg);
            out_len_reg   <= count_reg;
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.position = out_pos_reg;
    assign result.found    = out_found_reg;
    assign result.length   = out_len_reg;
    assign result.overflow = out_ovf_reg;

endmodule

`default_nettype wire

// ===== rtl/pattern_substring_search_core.sv =====
// Channel  | Dir | Word
// ---------+-----+-------------------------------------------
// item     | in  | mode, slot, value (pattern slot / element / end)
// result   | out | position, found, length, overflow
// apb      | in  | pattern_length at 0x0, find_last at 0x4
//
// One word per cycle: an input register feeds the window compare and the
// run counters, and end words load a result register.
// Input stalls only when an end word waits while the result register is full.
// rst_n is asynchronous; it clears the window, counters and registers but
// not the pattern slots.
`default_nettype none

`include "pattern_substring_search_core_defines.svh"

module pattern_substring_search_core #(
    parameter int PATTERN_MAX  = pss_pkg::PATTERN_MAX_DEF,
    parameter int ELEMENT_BITS = pss_pkg::ELEMENT_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pss_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [pss_pkg::DATA_W-1:0]  pwdata,
    output logic      [pss_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    pss_in_if.sink                           item,
    pss_out_if.source                        result
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    logic                         s1_valid_reg;
    pss_pkg::pss_mode_t           s1_mode_reg;
    logic [pss_pkg::SLOT_W-1:0]   s1_slot_reg;
    logic [ELEMENT_BITS-1:0]      s1_value_reg;
    logic                         s1_go;
    logic                         out_free;
    logic [LEN_W-1:0]             used_len;
    logic                         find_last;
    logic                         hit;
    pss_pkg::pss_step_t           step;

    pss_cfg #(
        .PATTERN_MAX (PATTERN_MAX),
        .LEN_W       (LEN_W)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .used_len  (used_len),
        .find_last (find_last)
    );

    // Input stage advances unless an end word meets a full result register
    assign s1_go      = (s1_mode_reg != pss_pkg::MODE_END) || out_free;
    assign item.ready = !s1_valid_reg || s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (item.ready)
            s1_valid_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            s1_mode_reg  <= pss_pkg::pss_mode_t'(item.mode);
            s1_slot_reg  <= item.slot;
            s1_value_reg <= item.value[ELEMENT_BITS-1:0];
        end
    end

    // Decode the word in the input stage
    always_comb
    begin
        step = '0;
        if (s1_valid_reg && s1_go)
        begin
            case (s1_mode_reg)
                pss_pkg::MODE_PATTERN: step.load   = 1'b1;
                pss_pkg::MODE_ELEMENT: step.shift  = 1'b1;
                pss_pkg::MODE_END:     step.finish = 1'b1;
                default:               step        = '0;
            endcase
        end
    end

    pss_window #(
        .PATTERN_MAX  (PATTERN_MAX),
        .ELEMENT_BITS (ELEMENT_BITS),
        .LEN_W        (LEN_W)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .slot     (s1_slot_reg),
        .value    (s1_value_reg),
        .used_len (used_len),
        .hit      (hit)
    );

    pss_tracker #(
        .PATTERN_MAX (PATTERN_MAX),
        .LEN_W       (LEN_W)
    ) u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .hit       (hit),
        .used_len  (used_len),
        .find_last (find_last),
        .out_free  (out_free),
        .result    (result)
    );

    // Checks
    `PSS_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (!result.valid && item.ready), "not idle in reset")
    `PSS_ASSERT(a_result_from_end, $rose(result.valid) |-> $past(step.finish), "result without end word")
    `PSS_ASSERT(a_stall_cause, !item.ready |-> (s1_valid_reg && (s1_mode_reg == pss_pkg::MODE_END) && result.valid && !result.ready), "input stalled without cause")
    `PSS_ASSERT(a_found_before_end, (result.valid && result.found) |-> (result.position < result.length), "match start beyond haystack")
    `PSS_ASSERT(a_overflow_saturated, (result.valid && result.overflow) |-> (result.length == pss_pkg::COUNT_MAX), "overflow below saturation")

endmodule

`default_nettype wire

// ===== bench/pattern_search_checker.sv =====
`timescale 1ns / 100ps

// Watches the config port and both word channels, predicts each search
// result and compares it with what the block returns.
module pattern_search_checker (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic                       pready,
    input  wire logic [pss_pkg::ADDR_W-1:0] paddr,
    input  wire logic [pss_pkg::DATA_W-1:0] pwdata,
    pss_in_if                               item,
    pss_out_if                              result,
    output int                              errors,
    output int                              waiting
);
    import pss_pkg::*;

    localparam int SLOTS = PATTERN_MAX_DEF;
    localparam int COUNT_LIMIT = int'(COUNT_MAX);
    localparam logic [VALUE_W-1:0] VALUE_MASK = VALUE_W'((1 << ELEMENT_BITS_DEF) - 1);
    localparam int PRINT_LIMIT = 40;

    typedef struct {
        logic [COUNT_W-1:0] position;
        logic               found;
        logic [COUNT_W-1:0] length;
        logic               overflow;
    } search_report_t;

    search_report_t expected_reports[$];

    // predicted block state
    logic [VALUE_W-1:0] slot_value [SLOTS];
    logic [VALUE_W-1:0] recent [SLOTS];
    int                 seen_count;
    logic               saturated;
    int                 start_kept;
    logic               hit_seen;
    logic [PLEN_W-1:0]  plen_reg;
    logic               keep_last;

    int error_count = 0;

    task automatic report_error(string msg);
        if (error_count < PRINT_LIMIT)
            $display("[%0t] search result: %s", $time, msg);
        error_count++;
    endtask

    task automatic clear_run();
        foreach (recent[i])
            recent[i] = '0;
        seen_count = 0;
        saturated  = 1'b0;
        start_kept = 0;
        hit_seen   = 1'b0;
    endtask

    // pattern length beyond the store is clipped to the store size
    function automatic int used_len();
        return (plen_reg > SLOTS) ? SLOTS : int'(plen_reg);
    endfunction

    function automatic bit window_hit(int len);
        int k;
        if (len == 0 || seen_count < len)
            return 1'b0;
        for (k = 0; k < len; k++)
            if (recent[len-1-k] != slot_value[k])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic take_word(logic [MODE_W-1:0] m, logic [SLOT_W-1:0] s,
                             logic [VALUE_W-1:0] v);
        int len;
        int pos;
        search_report_t rep;
        len = used_len();
        case (m)
            MODE_PATTERN:
            begin
                if (s < SLOTS)
                    slot_value[s] = v & VALUE_MASK;
            end
            MODE_ELEMENT:
            begin
                for (int i = SLOTS - 1; i > 0; i--)
                    recent[i] = recent[i-1];
                recent[0] = v & VALUE_MASK;
                if (seen_count >= COUNT_LIMIT)
                    saturated = 1'b1;
                else
                    seen_count++;
                // no start updates once the counter has saturated
                if (!saturated && window_hit(len))
                begin
                    if (keep_last || !hit_seen)
                        start_kept = seen_count - len;
                    hit_seen = 1'b1;
                end
            end
            MODE_END:
            begin
                // empty pattern: 0 in first mode, length in last mode
                if (len == 0)
                    pos = keep_last ? seen_count : 0;
                else
                    pos = hit_seen ? start_kept : seen_count;
                rep.position = COUNT_W'(pos);
                rep.found    = (pos != seen_count);
                rep.length   = COUNT_W'(seen_count);
                rep.overflow = saturated;
                expected_reports.push_back(rep);
                clear_run();
            end
            default: ;
        endcase
    endtask

    task automatic check_result();
        search_report_t want;
        if (expected_reports.size() == 0)
        begin
            report_error($sformatf("word with nothing expected, position %0d length %0d",
                                   result.position, result.length));
            return;
        end
        want = expected_reports.pop_front();
        if (result.position !== want.position)
            report_error($sformatf("position %0d, want %0d", result.position, want.position));
        if (result.found !== want.found)
            report_error($sformatf("found %0b, want %0b", result.found, want.found));
        if (result.length !== want.length)
            report_error($sformatf("length %0d, want %0d", result.length, want.length));
        if (result.overflow !== want.overflow)
            report_error($sformatf("overflow %0b, want %0b", result.overflow, want.overflow));
    endtask

    // sample everything at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg  = '0;
            keep_last = 1'b0;
            clear_run();
            expected_reports.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == {REG_PATTERN_LENGTH, 2'b00})
                    plen_reg = pwdata[PLEN_W-1:0];
                else if (paddr == {REG_FIND_LAST, 2'b00})
                    keep_last = pwdata[0];
            end
            if (result.valid && result.ready)
                check_result();
            if (item.valid && item.ready)
                take_word(item.mode, item.slot, item.value);
        end
        errors  = error_count;
        waiting = expected_reports.size();
    end

endmodule

// ===== bench/pattern_substring_search_core_test.sv =====
`timescale 1ns / 100ps

module pattern_substring_search_core_test;
    import pss_pkg::*;

    localparam int SLOTS         = PATTERN_MAX_DEF;
    localparam int RANDOM_WORDS  = 1600;
    localparam int IDLE_LIMIT    = 3000;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int OVERFLOW_RUN  = 65540;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    int                errors;
    int                waiting;

    pss_in_if  item_ch ();
    pss_out_if result_ch ();

    pattern_substring_search_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .item    (item_ch),
        .result  (result_ch)
    );

    pattern_search_checker search_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .pready  (pready),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .item    (item_ch),
        .result  (result_ch),
        .errors  (errors),
        .waiting (waiting)
    );

    // stimulus-side copy of the pattern, used to plant occurrences
    logic [VALUE_W-1:0] slot_copy [SLOTS];
    logic [VALUE_W-1:0] alphabet [4];
    int                 cur_len;
    int                 burst_left = 0;
    int                 word_count = 0;
    int                 idle_cycles = 0;
    bit                 hold_req = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // one word per call; the sender works in bursts with random gaps
    task automatic send_word(logic [MODE_W-1:0] m, logic [SLOT_W-1:0] s,
                             logic [VALUE_W-1:0] v);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        item_ch.valid <= 1'b1;
        item_ch.mode  <= m;
        item_ch.slot  <= s;
        item_ch.value <= v;
        if (m != MODE_UNUSED)
            word_count++;
        do
            @(posedge clk);
        while (!item_ch.ready);
    endtask

    task automatic idle_sender();
        @(negedge clk);
        item_ch.valid <= 1'b0;
    endtask

    task automatic write_slot(int s, logic [VALUE_W-1:0] v);
        send_word(MODE_PATTERN, SLOT_W'(s), v);
        slot_copy[s] = v;
    endtask

    task automatic write_reg(pss_reg_t r, logic [DATA_W-1:0] d);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= d;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(logic [DATA_W-1:0] plen_word, logic [DATA_W-1:0] last_word);
        write_reg(REG_PATTERN_LENGTH, plen_word);
        write_reg(REG_FIND_LAST, last_word);
        cur_len = (plen_word[PLEN_W-1:0] > SLOTS) ? SLOTS : int'(plen_word[PLEN_W-1:0]);
    endtask

    // drain all results, then let words with no result clear the pipe
    task automatic settle();
        idle_sender();
        while (waiting != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic send_element(logic [VALUE_W-1:0] v);
        send_word(MODE_ELEMENT, SLOT_W'($urandom), v);
    endtask

    task automatic send_end();
        send_word(MODE_END, SLOT_W'($urandom), VALUE_W'($urandom));
    endtask

    // random haystack with planted, sometimes cut short, occurrences
    task automatic send_haystack(int n);
        int sent;
        int pick;
        int cut;
        sent = 0;
        while (sent < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                send_word(MODE_UNUSED, SLOT_W'($urandom), VALUE_W'($urandom));
            else if (pick < 6)
                write_slot($urandom_range(0, SLOTS - 1), alphabet[$urandom_range(0, 3)]);
            else if (pick < 28 && cur_len > 0)
            begin
                cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, cur_len) : cur_len;
                for (int k = 0; k < cut; k++)
                    send_element(slot_copy[k]);
                sent += cut;
            end
            else
            begin
                if (pick < 33)
                    send_element(VALUE_W'($urandom));
                else
                    send_element(alphabet[$urandom_range(0, 3)]);
                sent++;
            end
        end
        send_end();
    endtask

    // receiver: stall pattern of its own, plus one long hold on request
    initial
    begin
        int  stretch;
        int  style;
        int  hold_left;
        bit  held;
        result_ch.ready = 1'b0;
        stretch   = 0;
        style     = 0;
        hold_left = 0;
        held      = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !held)
            begin
                held      = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                if (stretch == 0)
                begin
                    style   = $urandom_range(0, 3);
                    stretch = $urandom_range(16, 96);
                end
                stretch--;
                case (style)
                    0: result_ch.ready <= 1'b1;
                    1: result_ch.ready <= ($urandom_range(0, 3) != 0);
                    2: result_ch.ready <= (stretch % 3 == 0);
                    default: result_ch.ready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) || psel)
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("pattern_substring_search_core_test: done, errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int                phase;
        int                plen;
        int                n;
        logic [DATA_W-1:0] plen_word;
        logic [DATA_W-1:0] last_word;

        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        item_ch.valid = 1'b0;
        item_ch.mode  = MODE_PATTERN;
        item_ch.slot  = '0;
        item_ch.value = '0;
        cur_len       = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty pattern in first mode, with and without a haystack
        send_end();
        send_element(16'hFFFF);
        send_element(16'h0000);
        send_end();
        send_word(MODE_UNUSED, 4'hF, 16'hFFFF);
        write_slot(0, 16'h0000);
        write_slot(1, 16'hFFFF);
        write_slot(15, 16'h8001);
        settle();

        // two-element pattern, last mode, junk in the upper register bits
        set_config(32'hFFFF_FFE2, 32'hFFFF_FFFF);
        send_element(16'h0000);
        send_end();
        send_element(16'h0000);
        send_element(16'hFFFF);
        send_element(16'h0000);
        send_element(16'hFFFF);
        send_end();
        settle();

        // same haystack, first mode
        write_reg(REG_FIND_LAST, 32'hFFFF_FFFE);
        send_element(16'h0000);
        send_element(16'hFFFF);
        send_element(16'h0000);
        send_element(16'hFFFF);
        send_end();
        settle();

        // empty pattern in last mode
        set_config(32'd0, 32'd1);
        send_element(16'h0007);
        send_end();
        settle();

        // random phases; every slot gets a value before any long pattern
        word_count = 0;
        foreach (alphabet[i])
            alphabet[i] = VALUE_W'($urandom);
        for (int s = 0; s < SLOTS; s++)
            write_slot(s, ($urandom_range(0, 3) == 0) ? VALUE_W'($urandom)
                                                       : alphabet[$urandom_range(0, 3)]);
        phase = 0;
        while (word_count < RANDOM_WORDS)
        begin
            settle();
            case ($urandom_range(0, 9))
                0: plen = 0;
                1: plen = 1;
                2: plen = SLOTS;
                3: plen = $urandom_range(SLOTS + 1, 31);
                4: plen = $urandom_range(7, SLOTS - 1);
                default: plen = $urandom_range(2, 6);
            endcase
            plen_word = $urandom;
            plen_word[PLEN_W-1:0] = PLEN_W'(plen);
            last_word = $urandom;
            set_config(plen_word, last_word);

            // fresh small alphabet so matches are common
            foreach (alphabet[i])
                alphabet[i] = VALUE_W'($urandom);
            if ($urandom_range(0, 2) == 0)
                alphabet[2] = alphabet[0];
            for (int s = 0; s < SLOTS; s++)
                if (s < cur_len || $urandom_range(0, 3) == 0)
                    write_slot(s, alphabet[$urandom_range(0, 3)]);

            if (phase == 2)
            begin
                // receiver holds off while short runs pile up behind it
                hold_req = 1'b1;
                repeat (12) send_haystack($urandom_range(0, 2));
            end
            repeat ($urandom_range(3, 8))
            begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 70) : $urandom_range(0, 20);
                send_haystack(n);
            end
            phase++;
        end
        settle();

        // one long haystack to saturate the counter, last mode, every element a hit
        set_config(32'd1, 32'd1);
        write_slot(0, 16'hA5A5);
        repeat (OVERFLOW_RUN) send_element(16'hA5A5);
        send_end();
        settle();

        if (errors == 0 && waiting == 0)
            $display("pattern_substring_search_core_test: done, clean");
        else
            $display("pattern_substring_search_core_test: done, errors");
        $finish;
    end

endmodule
